>>> hw/rtl/dlf_pkg.sv
// ----------------------------------------------------------------------------
// Decaying line fit package
// Shared widths, register indexes and the types that travel between the
// front end, the item queue and the arithmetic back end.
// ----------------------------------------------------------------------------
package dlf_pkg;

   // Sample and running sum widths; every sum carries FRAC fractional bits.
   localparam int SAMPLE_W = 16;
   localparam int FRAC     = 16;
   localparam int W_W      = 20;
   localparam int S_W      = SAMPLE_W + 20;
   localparam int P_W      = 2 * SAMPLE_W + 20;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int CFG_W    = 16;
   localparam int OUT_W    = 32;

   // Accumulator, determinant and divider widths.
   localparam int ACC_W = P_W + S_W + 2;
   localparam int NUM_W = ACC_W - 1;
   localparam int DET_W = W_W + P_W + 2;
   localparam int REM_W = DET_W - 1;
   localparam int DVD_W = NUM_W + FRAC;
   localparam int B_W   = S_W + 1;
   localparam int CNT_W = $clog2(DVD_W);

   // Item queue depth.
   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 1'b1;
   localparam logic [CFG_W-1:0] DECAY_RST  = 16'd53655;
   localparam logic [CFG_W-1:0] THRESH_RST = 16'd0;

   // One queued sample with its precomputed products.
   typedef struct packed {
      logic [SAMPLE_W-1:0] xs;
      logic [SAMPLE_W-1:0] ys;
      logic [PROD_W-1:0]   xx_p;
      logic [PROD_W-1:0]   xy_p;
   } entry_type;

   // Configuration seen by the back end.
   typedef struct packed {
      logic [CFG_W-1:0] decay;
      logic [CFG_W-1:0] thresh;
   } cfg_type;

   // Queue status seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> hw/rtl/dlf_front.sv
// ----------------------------------------------------------------------------
// Decaying line fit front end
// Takes input transfers while the queue has room and forms the squared
// and cross products of each sample before queuing it.
// ----------------------------------------------------------------------------
module dlf_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dlf_pkg::SAMPLE_W-1:0] req_x_sample,
   input  logic [dlf_pkg::SAMPLE_W-1:0] req_y_sample,
   input  dlf_pkg::qstat_type           qstat,
   output logic                         q_push,
   output dlf_pkg::entry_type           q_entry
);
   import dlf_pkg::*;

   logic signed [PROD_W-1:0] xs_e;
   logic signed [PROD_W-1:0] ys_e;
   logic signed [PROD_W-1:0] xx_s;
   logic signed [PROD_W-1:0] xy_s;

   // A transfer is taken whenever the queue can hold it.
   assign req_stall = qstat.full;
   assign q_push    = req_valid & ~qstat.full;

   // Sample products, exact in PROD_W bits.
   always_comb begin
      xs_e = PROD_W'($signed(req_x_sample));
      ys_e = PROD_W'($signed(req_y_sample));
      xx_s = xs_e * xs_e;
      xy_s = xs_e * ys_e;
      q_entry.xs   = req_x_sample;
      q_entry.ys   = req_y_sample;
      q_entry.xx_p = xx_s;
      q_entry.xy_p = xy_s;
   end

endmodule

>>> hw/rtl/dlf_queue.sv
// ----------------------------------------------------------------------------
// Decaying line fit item queue
// A short first-in first-out buffer that decouples the front end from the
// sequential back end.
// ----------------------------------------------------------------------------
module dlf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  dlf_pkg::entry_type q_entry,
   input  logic               q_pop,
   output dlf_pkg::entry_type q_head,
   output dlf_pkg::qstat_type qstat
);
   import dlf_pkg::*;

   entry_type         mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == QCNT_W'(Q_DEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign q_head      = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (q_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!q_push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ptr_ff] <= q_entry;
      end
   end

endmodule

>>> hw/rtl/dlf_back.sv
// ----------------------------------------------------------------------------
// Decaying line fit back end
// Decays and updates the five running sums, forms the determinant and the
// two numerators with a bit-serial multiplier, divides with a restoring
// divider and holds the result in the output register.
// ----------------------------------------------------------------------------
module dlf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  dlf_pkg::cfg_type          cfg,
   input  dlf_pkg::qstat_type        qstat,
   input  dlf_pkg::entry_type        q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [dlf_pkg::OUT_W-1:0] rsp_slope,
   output logic [dlf_pkg::OUT_W-1:0] rsp_intercept,
   output logic                      rsp_fit_valid
);
   import dlf_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LOAD = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_POST = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_FIN  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   typedef enum logic [3:0] {
      OP_DW   = 4'd0,
      OP_DX   = 4'd1,
      OP_DY   = 4'd2,
      OP_DXX  = 4'd3,
      OP_DXY  = 4'd4,
      OP_DET0 = 4'd5,
      OP_DET1 = 4'd6,
      OP_SN0  = 4'd7,
      OP_SN1  = 4'd8,
      OP_IN0  = 4'd9,
      OP_IN1  = 4'd10
   } op_type;

   localparam int DEC_LEN = CFG_W + 1;
   localparam int WB_LEN  = W_W + 1;
   localparam int SB_LEN  = S_W;

   // Control state.
   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [W_W-1:0]       w_ff, w_in;
   logic [S_W-1:0]       x_ff, x_in;
   logic [S_W-1:0]       y_ff, y_in;
   logic [P_W-1:0]       xx_ff, xx_in;
   logic [P_W-1:0]       xy_ff, xy_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   entry_type            ent_ff, ent_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0]     a_ff, a_in;
   logic [B_W-1:0]       b_ff, b_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 sub_ff, sub_in;
   logic [REM_W-1:0]     det_ff, det_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [OUT_W:0]       q_ff, q_in;
   logic                 ovf_ff, ovf_in;
   logic                 neg_ff, neg_in;
   logic [OUT_W-1:0]     slope_ff, slope_in;
   logic [OUT_W-1:0]     inter_ff, inter_in;
   logic                 fit_ff, fit_in;
   logic [OUT_W-1:0]     rsp_slope_ff, rsp_slope_in;
   logic [OUT_W-1:0]     rsp_inter_ff, rsp_inter_in;
   logic                 rsp_fit_ff, rsp_fit_in;

   // Working signals.
   logic [ACC_W-1:0]     a_sel;
   logic [B_W-1:0]       b_sel;
   logic [CNT_W-1:0]     len_sel;
   logic                 clr_sel;
   logic                 sub_sel;
   logic                 neg_term;
   logic signed [ACC_W-1:0] addend;
   logic [W_W:0]         w_add;
   logic signed [S_W:0]  x_add;
   logic signed [S_W:0]  y_add;
   logic [P_W:0]         xx_add;
   logic signed [P_W:0]  xy_add;
   logic [NUM_W-1:0]     mag;
   logic [REM_W+1:0]     trial;
   logic                 ge;
   logic                 out_free;

   // Signed Q16.16 saturation of a quotient magnitude with its sign.
   function automatic logic [OUT_W-1:0] sat_quot(input logic [OUT_W:0] q,
                                                 input logic ovf, input logic neg);
      logic big_pos;
      logic big_neg;
      big_pos = ovf | q[OUT_W] | q[OUT_W-1];
      big_neg = ovf | q[OUT_W] | (q[OUT_W-1] & (|q[OUT_W-2:0]));
      if (neg) begin
         sat_quot = big_neg ? {1'b1, {(OUT_W-1){1'b0}}} : (~q[OUT_W-1:0] + 1'b1);
      end else begin
         sat_quot = big_pos ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
      end
   endfunction

   assign q_pop         = (state_ff == ST_IDLE) && !qstat.empty;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slope     = rsp_slope_ff;
   assign rsp_intercept = rsp_inter_ff;
   assign rsp_fit_valid = rsp_fit_ff;
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the multiplier, decoded from the current step.
   always_comb begin
      a_sel   = '0;
      b_sel   = B_W'($signed({1'b0, cfg.decay}));
      len_sel = CNT_W'(DEC_LEN - 1);
      clr_sel = 1'b1;
      sub_sel = 1'b0;
      unique case (op_ff)
         OP_DW:   a_sel = ACC_W'({1'b0, w_ff});
         OP_DX:   a_sel = ACC_W'($signed(x_ff));
         OP_DY:   a_sel = ACC_W'($signed(y_ff));
         OP_DXX:  a_sel = ACC_W'({1'b0, xx_ff});
         OP_DXY:  a_sel = ACC_W'($signed(xy_ff));
         OP_DET0: begin
            a_sel   = ACC_W'({1'b0, xx_ff});
            b_sel   = B_W'({1'b0, w_ff});
            len_sel = CNT_W'(WB_LEN - 1);
         end
         OP_DET1: begin
            a_sel   = ACC_W'($signed(x_ff));
            b_sel   = B_W'($signed(x_ff));
            len_sel = CNT_W'(SB_LEN - 1);
            clr_sel = 1'b0;
            sub_sel = 1'b1;
         end
         OP_SN0: begin
            a_sel   = ACC_W'($signed(xy_ff));
            b_sel   = B_W'({1'b0, w_ff});
            len_sel = CNT_W'(WB_LEN - 1);
         end
         OP_SN1: begin
            a_sel   = ACC_W'($signed(y_ff));
            b_sel   = B_W'($signed(x_ff));
            len_sel = CNT_W'(SB_LEN - 1);
            clr_sel = 1'b0;
            sub_sel = 1'b1;
         end
         OP_IN0: begin
            a_sel   = ACC_W'({1'b0, xx_ff});
            b_sel   = B_W'($signed(y_ff));
            len_sel = CNT_W'(SB_LEN - 1);
         end
         OP_IN1: begin
            a_sel   = ACC_W'($signed(xy_ff));
            b_sel   = B_W'($signed(x_ff));
            len_sel = CNT_W'(SB_LEN - 1);
            clr_sel = 1'b0;
            sub_sel = 1'b1;
         end
         default: a_sel = '0;
      endcase
   end

   // Multiplier step, sum update, divider step.
   always_comb begin
      // The top multiplier bit carries negative weight.
      neg_term = sub_ff ^ (cnt_ff == '0);
      addend   = b_ff[0] ? (neg_term ? -$signed(a_ff) : $signed(a_ff)) : '0;

      // Decayed sums plus the new sample, before saturation.
      w_add  = {1'b0, acc_ff[W_W+FRAC-1:FRAC]} + (W_W+1)'(1 << FRAC);
      x_add  = (S_W+1)'($signed(acc_ff[S_W+FRAC-1:FRAC]))
               + (S_W+1)'($signed({ent_ff.xs, {FRAC{1'b0}}}));
      y_add  = (S_W+1)'($signed(acc_ff[S_W+FRAC-1:FRAC]))
               + (S_W+1)'($signed({ent_ff.ys, {FRAC{1'b0}}}));
      xx_add = {1'b0, acc_ff[P_W+FRAC-1:FRAC]} + (P_W+1)'({ent_ff.xx_p, {FRAC{1'b0}}});
      xy_add = (P_W+1)'($signed(acc_ff[P_W+FRAC-1:FRAC]))
               + (P_W+1)'($signed({ent_ff.xy_p, {FRAC{1'b0}}}));

      // Numerator magnitude and the trial subtraction of the divider.
      mag   = acc_ff[ACC_W-1] ? (~acc_ff[NUM_W-1:0] + 1'b1) : acc_ff[NUM_W-1:0];
      trial = {1'b0, rem_ff, dvd_ff[DVD_W-1]} - {2'b00, det_ff};
      ge    = !trial[REM_W+1];
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      w_in         = w_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xx_in        = xx_ff;
      xy_in        = xy_ff;
      ent_in       = ent_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cnt_in       = cnt_ff;
      sub_in       = sub_ff;
      det_in       = det_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      slope_in     = slope_ff;
      inter_in     = inter_ff;
      fit_in       = fit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slope_in = rsp_slope_ff;
      rsp_inter_in = rsp_inter_ff;
      rsp_fit_in   = rsp_fit_ff;

      // Output register empties on a result transfer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               ent_in   = q_head;
               op_in    = OP_DW;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            a_in   = a_sel;
            b_in   = b_sel;
            cnt_in = len_sel;
            sub_in = sub_sel;
            if (clr_sel) begin
               acc_in = '0;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_in = acc_ff + addend;
            a_in   = a_ff << 1;
            b_in   = {b_ff[B_W-1], b_ff[B_W-1:1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            state_in = ST_LOAD;
            unique case (op_ff)
               OP_DW: begin
                  w_in  = w_add[W_W] ? {W_W{1'b1}} : w_add[W_W-1:0];
                  op_in = OP_DX;
               end
               OP_DX: begin
                  if (x_add[S_W] != x_add[S_W-1]) begin
                     x_in = x_add[S_W] ? {1'b1, {(S_W-1){1'b0}}} : {1'b0, {(S_W-1){1'b1}}};
                  end else begin
                     x_in = x_add[S_W-1:0];
                  end
                  op_in = OP_DY;
               end
               OP_DY: begin
                  if (y_add[S_W] != y_add[S_W-1]) begin
                     y_in = y_add[S_W] ? {1'b1, {(S_W-1){1'b0}}} : {1'b0, {(S_W-1){1'b1}}};
                  end else begin
                     y_in = y_add[S_W-1:0];
                  end
                  op_in = OP_DXX;
               end
               OP_DXX: begin
                  xx_in = xx_add[P_W] ? {P_W{1'b1}} : xx_add[P_W-1:0];
                  op_in = OP_DXY;
               end
               OP_DXY: begin
                  if (xy_add[P_W] != xy_add[P_W-1]) begin
                     xy_in = xy_add[P_W] ? {1'b1, {(P_W-1){1'b0}}}
                                         : {1'b0, {(P_W-1){1'b1}}};
                  end else begin
                     xy_in = xy_add[P_W-1:0];
                  end
                  op_in = OP_DET0;
               end
               OP_DET0: op_in = OP_DET1;
               OP_DET1: begin
                  // The determinant must be positive and above the threshold.
                  if (!acc_ff[ACC_W-1] &&
                      (acc_ff[REM_W-1:0] > REM_W'({cfg.thresh, {FRAC{1'b0}}}))) begin
                     det_in = acc_ff[REM_W-1:0];
                     op_in  = OP_SN0;
                  end else begin
                     slope_in = '0;
                     inter_in = '0;
                     fit_in   = 1'b0;
                     state_in = ST_OUT;
                  end
               end
               OP_SN0: op_in = OP_SN1;
               OP_IN0: op_in = OP_IN1;
               OP_SN1, OP_IN1: begin
                  neg_in   = acc_ff[ACC_W-1];
                  dvd_in   = {mag, {FRAC{1'b0}}};
                  rem_in   = '0;
                  q_in     = '0;
                  ovf_in   = 1'b0;
                  cnt_in   = CNT_W'(DVD_W - 1);
                  state_in = ST_DIV;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIV: begin
            // One quotient bit per cycle; bits above the output are kept sticky.
            rem_in = ge ? trial[REM_W-1:0] : {rem_ff[REM_W-2:0], dvd_ff[DVD_W-1]};
            q_in   = {q_ff[OUT_W-1:0], ge};
            ovf_in = ovf_ff | q_ff[OUT_W];
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (op_ff == OP_SN1) begin
               slope_in = sat_quot(q_ff, ovf_ff, neg_ff);
               op_in    = OP_IN0;
               state_in = ST_LOAD;
            end else begin
               inter_in = sat_quot(q_ff, ovf_ff, neg_ff);
               fit_in   = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slope_in = slope_ff;
               rsp_inter_in = inter_ff;
               rsp_fit_in   = fit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and sum registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DW;
         w_ff         <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         xx_ff        <= '0;
         xy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         w_ff         <= w_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         xx_ff        <= xx_in;
         xy_ff        <= xy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and payload registers.
   always_ff @(posedge clock) begin
      ent_ff       <= ent_in;
      acc_ff       <= acc_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      cnt_ff       <= cnt_in;
      sub_ff       <= sub_in;
      det_ff       <= det_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      ovf_ff       <= ovf_in;
      neg_ff       <= neg_in;
      slope_ff     <= slope_in;
      inter_ff     <= inter_in;
      fit_ff       <= fit_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_inter_ff <= rsp_inter_in;
      rsp_fit_ff   <= rsp_fit_in;
   end

endmodule

>>> hw/rtl/decaying_line_fit.sv
// ----------------------------------------------------------------------------
// Decaying line fit top level
// Throughput: one item at a time; the bit-serial multiplier (one multiplier
// bit per cycle over up to eleven products) and the restoring divider (two
// quotients per item that is fitted) set the pace. A two-entry queue takes inputs.
// Reset clears the sums and the queue; the decay multiplier is 53655, threshold 0.
// ----------------------------------------------------------------------------
module decaying_line_fit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dlf_pkg::SAMPLE_W-1:0]  req_x_sample,
   input  logic [dlf_pkg::SAMPLE_W-1:0]  req_y_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dlf_pkg::OUT_W-1:0]     rsp_slope,
   output logic [dlf_pkg::OUT_W-1:0]     rsp_intercept,
   output logic                          rsp_fit_valid,
   input  logic                          csr_write_en,
   input  logic [dlf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dlf_pkg::CFG_W-1:0]     csr_wdata
);
   import dlf_pkg::*;

   logic [CFG_W-1:0] decay_ff, decay_in;
   logic [CFG_W-1:0] thresh_ff, thresh_in;
   cfg_type          cfg;
   qstat_type        qstat;
   logic             q_push;
   logic             q_pop;
   entry_type        q_entry;
   entry_type        q_head;

   // Configuration registers.
   always_comb begin
      decay_in  = decay_ff;
      thresh_in = thresh_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DECAY:  decay_in  = csr_wdata;
            CSR_THRESH: thresh_in = csr_wdata;
            default:    decay_in  = decay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= DECAY_RST;
         thresh_ff <= THRESH_RST;
      end else begin
         decay_ff  <= decay_in;
         thresh_ff <= thresh_in;
      end
   end

   assign cfg.decay  = decay_ff;
   assign cfg.thresh = thresh_ff;

   dlf_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_sample (req_x_sample),
      .req_y_sample (req_y_sample),
      .qstat        (qstat),
      .q_push       (q_push),
      .q_entry      (q_entry)
   );

   dlf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .qstat   (qstat)
   );

   dlf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .qstat         (qstat),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_slope     (rsp_slope),
      .rsp_intercept (rsp_intercept),
      .rsp_fit_valid (rsp_fit_valid)
   );

   // The front end never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !qstat.full)
      else $error("queue written while full");

   // The back end never takes from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !qstat.empty)
      else $error("queue read while empty");

   // A result without a fit carries zeros.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fit_valid) |-> (rsp_slope == '0 && rsp_intercept == '0))
      else $error("result without fit is not zero");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decaying line fit testbench
// Streams (x, y) samples into the line fit and checks each slope, intercept
// and fit flag against a bit-exact predictor of the decayed sums and the
// two divisions. A directed table comes first, then random line-shaped
// and full-range samples under several decay and threshold settings, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
   import dlf_pkg::*;

   localparam int CLK_HALF    = 4;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE      = 600;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 108;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic [OUT_W-1:0] slope;
      logic [OUT_W-1:0] intercept;
      logic             fit_valid;
   } fit_type;

   typedef struct {
      logic [CFG_W-1:0]    decay;
      logic [CFG_W-1:0]    thresh;
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] y;
      bit                  typed;
      fit_type             want;
   } row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [SAMPLE_W-1:0]  req_x_sample;
   logic [SAMPLE_W-1:0]  req_y_sample;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [OUT_W-1:0]     rsp_slope;
   logic [OUT_W-1:0]     rsp_intercept;
   logic                 rsp_fit_valid;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // Predictor state: the five running sums and the two registers.
   wide_type         weight_acc, x_acc, y_acc, xx_acc, xy_acc;
   logic [CFG_W-1:0] decay_reg, thresh_reg;

   fit_type     pending_fits[$];
   int          error_count;
   int          mismatch_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   longint      cycle_count;
   row_type     rows[$];

   decaying_line_fit dut (.*);

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Cycle counter with a hard limit on the run.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Saturate a value to a signed or unsigned field of the given width.
   function automatic wide_type saturate(wide_type v, bit sgn, int bits);
      wide_type top;
      wide_type hi;
      wide_type lo;
      top = wide_type'(1) <<< (sgn ? bits - 1 : bits);
      hi = top - 1;
      lo = sgn ? -top : wide_type'(0);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Scale by the decay factor, flooring, then saturate.
   function automatic wide_type decayed(wide_type s, bit sgn, int bits);
      wide_type f;
      f = wide_type'({240'd0, decay_reg});
      return saturate((s * f) >>> FRAC, sgn, bits);
   endfunction

   // Quotient in Q16.16, truncated toward zero and saturated to 32 bits.
   function automatic logic [OUT_W-1:0] q16_ratio(wide_type num, wide_type det);
      wide_type q;
      q = saturate((num <<< FRAC) / det, 1'b1, OUT_W);
      return q[OUT_W-1:0];
   endfunction

   // Advance the sums by one sample and work out the fit it produces.
   function automatic fit_type advance_fit(logic [SAMPLE_W-1:0] xr,
                                           logic [SAMPLE_W-1:0] yr);
      wide_type xs;
      wide_type ys;
      wide_type det;
      wide_type lim;
      fit_type  f;
      xs = wide_type'($signed(xr));
      ys = wide_type'($signed(yr));
      weight_acc = decayed(weight_acc, 1'b0, W_W);
      x_acc      = decayed(x_acc, 1'b1, S_W);
      y_acc      = decayed(y_acc, 1'b1, S_W);
      xx_acc     = decayed(xx_acc, 1'b0, P_W);
      xy_acc     = decayed(xy_acc, 1'b1, P_W);
      weight_acc = saturate(weight_acc + (wide_type'(1) <<< FRAC), 1'b0, W_W);
      x_acc      = saturate(x_acc + (xs <<< FRAC), 1'b1, S_W);
      y_acc      = saturate(y_acc + (ys <<< FRAC), 1'b1, S_W);
      xx_acc     = saturate(xx_acc + ((xs * xs) <<< FRAC), 1'b0, P_W);
      xy_acc     = saturate(xy_acc + ((xs * ys) <<< FRAC), 1'b1, P_W);
      det = weight_acc * xx_acc - x_acc * x_acc;
      lim = wide_type'({240'd0, thresh_reg}) <<< FRAC;
      if (det > lim) begin
         f.slope     = q16_ratio(xy_acc * weight_acc - x_acc * y_acc, det);
         f.intercept = q16_ratio(xx_acc * y_acc - xy_acc * x_acc, det);
         f.fit_valid = 1'b1;
      end else begin
         f.slope     = '0;
         f.intercept = '0;
         f.fit_valid = 1'b0;
      end
      return f;
   endfunction

   // Wait for every outstanding fit, then let the block settle.
   task automatic drain();
      while (pending_fits.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register write while the block is idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = val;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == CSR_DECAY) decay_reg = val;
      else if (idx == CSR_THRESH) thresh_reg = val;
   endtask

   // Drive one sample and hold it until the transfer; record its fit.
   task automatic send_sample(logic [SAMPLE_W-1:0] xv, logic [SAMPLE_W-1:0] yv,
                              bit typed, fit_type want);
      fit_type f;
      int      gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_x_sample = xv;
      req_y_sample = yv;
      do @(posedge clock); while (req_stall);
      f = advance_fit(xv, yv);
      pending_fits.push_back(typed ? want : f);
      @(negedge clock);
   endtask

   // Random stall on the result side.
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Result checker.
   initial begin
      fit_type w;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_fits.size() == 0) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected fit transfer: slope %h intercept %h flag %b",
                           rsp_slope, rsp_intercept, rsp_fit_valid);
            end else begin
               w = pending_fits.pop_front();
               if (rsp_slope !== w.slope || rsp_intercept !== w.intercept ||
                   rsp_fit_valid !== w.fit_valid) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Fit mismatch: slope %h/%h intercept %h/%h flag %b/%b",
                              w.slope, rsp_slope, w.intercept, rsp_intercept,
                              w.fit_valid, rsp_fit_valid);
               end
            end
         end
      end
   end

   // Append a directed row.
   function automatic void add_row(logic [CFG_W-1:0] d, logic [CFG_W-1:0] t, int xv,
                                   int yv, bit typed);
      row_type r;
      r.decay  = d;
      r.thresh = t;
      r.x      = xv[SAMPLE_W-1:0];
      r.y      = yv[SAMPLE_W-1:0];
      r.typed  = typed;
      r.want   = '{slope: '0, intercept: '0, fit_valid: 1'b0};
      rows.push_back(r);
   endfunction

   // Main stimulus.
   initial begin
      int      p;
      int      n;
      int      xv;
      int      yv;
      int      slope_k;
      int      offset;
      int      span;
      int      noise;
      bit      line_mode;
      logic [CFG_W-1:0] d;
      logic [CFG_W-1:0] t;
      fit_type dummy;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_x_sample  = '0;
      req_y_sample  = '0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_DECAY;
      csr_wdata     = '0;
      error_count   = 0;
      mismatch_count = 0;
      send_idle_pct = 7;
      recv_idle_pct = 50;
      weight_acc = '0; x_acc = '0; y_acc = '0; xx_acc = '0; xy_acc = '0;
      decay_reg  = DECAY_RST;
      thresh_reg = THRESH_RST;
      dummy = '{slope: '0, intercept: '0, fit_valid: 1'b0};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table. With empty sums a zero sample leaves a zero
      // determinant; with a zero decay factor the determinant is always zero.
      add_row(DECAY_RST, THRESH_RST, 0, 0, 1'b1);
      add_row(DECAY_RST, THRESH_RST, 0, 0, 1'b1);
      add_row(DECAY_RST, THRESH_RST, 32767, 32767, 1'b0);
      add_row(DECAY_RST, THRESH_RST, -32768, -32768, 1'b0);
      add_row(DECAY_RST, THRESH_RST, -32768, 32767, 1'b0);
      add_row(DECAY_RST, THRESH_RST, 32767, -32768, 1'b0);
      add_row(DECAY_RST, THRESH_RST, 1, 2, 1'b0);
      add_row(DECAY_RST, THRESH_RST, 100, -50, 1'b0);
      add_row(DECAY_RST, THRESH_RST, -1, -1, 1'b0);
      add_row(16'd0, 16'd0, 5, 7, 1'b1);
      add_row(16'd0, 16'd0, -32768, 32767, 1'b1);
      add_row(16'd0, 16'd0, 32767, 0, 1'b1);
      add_row(16'hFFFF, 16'hFFFF, 32767, 32767, 1'b0);
      add_row(16'hFFFF, 16'hFFFF, -32768, -32768, 1'b0);
      add_row(16'hFFFF, 16'hFFFF, 32767, -32768, 1'b0);
      add_row(16'hFFFF, 16'hFFFF, -32768, 32767, 1'b0);
      add_row(16'hFFFF, 16'hFFFF, 3, 9, 1'b0);
      add_row(16'hFFFF, 16'd0, 1, 1, 1'b0);
      add_row(16'hFFFF, 16'd0, 2, -3, 1'b0);
      add_row(16'hFFFF, 16'd0, 0, 0, 1'b0);
      foreach (rows[i]) begin
         if (rows[i].decay != decay_reg || rows[i].thresh != thresh_reg) begin
            req_valid = 1'b0;
            drain();
            write_reg(CSR_DECAY, rows[i].decay);
            write_reg(CSR_THRESH, rows[i].thresh);
         end
         send_sample(rows[i].x, rows[i].y, rows[i].typed, rows[i].want);
      end

      // Random phases under changing settings and idling patterns.
      for (p = 0; p < PHASES; p++) begin
         req_valid = 1'b0;
         drain();
         case (p % 5)
            0: begin d = 16'hFFFF; t = 16'd0; end
            1: begin d = 16'd32768; t = 16'hFFFF; end
            2: begin d = 16'd0; t = 16'd0; end
            3: begin d = 16'd65000; t = 16'($urandom_range(0, 200)); end
            default: begin d = 16'($urandom); t = 16'($urandom); end
         endcase
         write_reg(CSR_DECAY, d);
         write_reg(CSR_THRESH, t);
         if (p < PHASES / 3) begin
            send_idle_pct = 7;
            recv_idle_pct = 50;
         end else if (p < 2 * PHASES / 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         slope_k = $urandom_range(0, 40) - 20;
         offset  = $urandom_range(0, 2000) - 1000;
         span    = ($urandom_range(1) == 1) ? 100 : 1500;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Mostly noisy points along a line, some full-range samples.
            line_mode = ($urandom_range(99) < 80);
            if (line_mode) begin
               noise = $urandom_range(0, 20) - 10;
               xv = $urandom_range(0, 2 * span) - span;
               yv = slope_k * xv + offset + noise;
               if (yv > 32767) yv = 32767;
               if (yv < -32768) yv = -32768;
            end else begin
               xv = $urandom;
               yv = $urandom;
            end
            send_sample(xv[SAMPLE_W-1:0], yv[SAMPLE_W-1:0], 1'b0, dummy);
         end
      end

      // Wait for the last fits, then report.
      req_valid = 1'b0;
      drain();
      error_count += pending_fits.size();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/dlf_pkg.sv
hw/rtl/dlf_front.sv
hw/rtl/dlf_queue.sv
hw/rtl/dlf_back.sv
hw/rtl/decaying_line_fit.sv
tb/sv/testbench.sv
